// ===== rtl/vsr_pkg.sv =====
// Shared types and constants for the version string recognizer.
// Holds the scan state codes, the character codes and the step record.
// No dependencies.
`default_nettype none
package vsr_pkg;

  typedef logic [4:0] scan_state_t;
  typedef logic [7:0] char_t;

  // One DFA step handed from the input register to the scanner
  typedef struct packed {
    logic  adv;
    char_t chr;
  } step_t;

  localparam scan_state_t ST_START = 5'd0;
  localparam scan_state_t ST_NUM   = 5'd1;
  localparam scan_state_t ST_DOT   = 5'd2;
  localparam scan_state_t ST_LET   = 5'd3;
  localparam scan_state_t ST_US    = 5'd4;
  localparam scan_state_t ST_A1    = 5'd5;
  localparam scan_state_t ST_A2    = 5'd6;
  localparam scan_state_t ST_A3    = 5'd7;
  localparam scan_state_t ST_A4    = 5'd8;
  localparam scan_state_t ST_B1    = 5'd9;
  localparam scan_state_t ST_B2    = 5'd10;
  localparam scan_state_t ST_B3    = 5'd11;
  localparam scan_state_t ST_R1    = 5'd12;
  localparam scan_state_t ST_P1    = 5'd13;
  localparam scan_state_t ST_PR    = 5'd14;
  localparam scan_state_t ST_SFX   = 5'd15;
  localparam scan_state_t ST_DASH  = 5'd16;
  localparam scan_state_t ST_DR    = 5'd17;
  localparam scan_state_t ST_REV   = 5'd18;
  localparam scan_state_t ST_REJ   = 5'd19;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_US    = 8'h5F;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_UC_A  = 8'h41;
  localparam char_t CH_UC_Z  = 8'h5A;
  localparam char_t CH_LC_A  = 8'h61;
  localparam char_t CH_LC_Z  = 8'h7A;
  localparam char_t CH_B     = 8'h62;
  localparam char_t CH_C     = 8'h63;
  localparam char_t CH_E     = 8'h65;
  localparam char_t CH_H     = 8'h68;
  localparam char_t CH_L     = 8'h6C;
  localparam char_t CH_P     = 8'h70;
  localparam char_t CH_R     = 8'h72;
  localparam char_t CH_T     = 8'h74;

endpackage
`default_nettype wire

// ===== rtl/vsr_dfa.sv =====
// Scan state register and one-byte transition logic of the recogniser.
// Depends on vsr_pkg for state codes, character codes and step_t.
`default_nettype none
module vsr_dfa (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vsr_pkg::step_t       step,
  output logic                      verdict,
  output vsr_pkg::scan_state_t      scan_state
);

  vsr_pkg::scan_state_t state_r;
  vsr_pkg::scan_state_t state_nxt;
  vsr_pkg::scan_state_t trans;
  vsr_pkg::scan_state_t after_sfx;
  logic                 dig;
  logic                 let_c;
  logic                 term;
  vsr_pkg::char_t       c;

  assign c     = step.chr;
  assign term  = (c == vsr_pkg::CH_NUL);
  assign dig   = (c >= vsr_pkg::CH_0) && (c <= vsr_pkg::CH_9);
  assign let_c = ((c >= vsr_pkg::CH_UC_A) && (c <= vsr_pkg::CH_UC_Z)) ||
                 ((c >= vsr_pkg::CH_LC_A) && (c <= vsr_pkg::CH_LC_Z));

  always_comb begin
    if (dig) begin
      after_sfx = vsr_pkg::ST_SFX;
    end else if (c == vsr_pkg::CH_US) begin
      after_sfx = vsr_pkg::ST_US;
    end else if (c == vsr_pkg::CH_DASH) begin
      after_sfx = vsr_pkg::ST_DASH;
    end else begin
      after_sfx = vsr_pkg::ST_REJ;
    end
  end

  always_comb begin
    trans = vsr_pkg::ST_REJ;
    unique case (state_r)
      vsr_pkg::ST_START: if (dig) trans = vsr_pkg::ST_NUM;
      vsr_pkg::ST_NUM: begin
        if (dig)                         trans = vsr_pkg::ST_NUM;
        else if (c == vsr_pkg::CH_DOT)   trans = vsr_pkg::ST_DOT;
        else if (let_c)                  trans = vsr_pkg::ST_LET;
        else if (c == vsr_pkg::CH_US)    trans = vsr_pkg::ST_US;
        else if (c == vsr_pkg::CH_DASH)  trans = vsr_pkg::ST_DASH;
      end
      vsr_pkg::ST_DOT: if (dig) trans = vsr_pkg::ST_NUM;
      vsr_pkg::ST_LET: begin
        if (c == vsr_pkg::CH_US)         trans = vsr_pkg::ST_US;
        else if (c == vsr_pkg::CH_DASH)  trans = vsr_pkg::ST_DASH;
      end
      vsr_pkg::ST_US: begin
        if (c == vsr_pkg::CH_LC_A)       trans = vsr_pkg::ST_A1;
        else if (c == vsr_pkg::CH_B)     trans = vsr_pkg::ST_B1;
        else if (c == vsr_pkg::CH_P)     trans = vsr_pkg::ST_P1;
        else if (c == vsr_pkg::CH_R)     trans = vsr_pkg::ST_R1;
      end
      vsr_pkg::ST_A1:   if (c == vsr_pkg::CH_L)    trans = vsr_pkg::ST_A2;
      vsr_pkg::ST_A2:   if (c == vsr_pkg::CH_P)    trans = vsr_pkg::ST_A3;
      vsr_pkg::ST_A3:   if (c == vsr_pkg::CH_H)    trans = vsr_pkg::ST_A4;
      vsr_pkg::ST_A4:   if (c == vsr_pkg::CH_LC_A) trans = vsr_pkg::ST_SFX;
      vsr_pkg::ST_B1:   if (c == vsr_pkg::CH_E)    trans = vsr_pkg::ST_B2;
      vsr_pkg::ST_B2:   if (c == vsr_pkg::CH_T)    trans = vsr_pkg::ST_B3;
      vsr_pkg::ST_B3:   if (c == vsr_pkg::CH_LC_A) trans = vsr_pkg::ST_SFX;
      vsr_pkg::ST_R1:   if (c == vsr_pkg::CH_C)    trans = vsr_pkg::ST_SFX;
      // "_pr" can only continue as "pre"
      vsr_pkg::ST_P1: begin
        if (c == vsr_pkg::CH_R) trans = vsr_pkg::ST_PR;
        else                    trans = after_sfx;
      end
      vsr_pkg::ST_PR:   if (c == vsr_pkg::CH_E)    trans = vsr_pkg::ST_SFX;
      vsr_pkg::ST_SFX:  trans = after_sfx;
      vsr_pkg::ST_DASH: if (c == vsr_pkg::CH_R)    trans = vsr_pkg::ST_DR;
      vsr_pkg::ST_DR:   if (dig) trans = vsr_pkg::ST_REV;
      vsr_pkg::ST_REV:  if (dig) trans = vsr_pkg::ST_REV;
      default:          trans = vsr_pkg::ST_REJ;
    endcase
  end

  always_comb begin
    verdict = (state_r == vsr_pkg::ST_NUM) || (state_r == vsr_pkg::ST_LET) ||
              (state_r == vsr_pkg::ST_P1)  || (state_r == vsr_pkg::ST_SFX) ||
              (state_r == vsr_pkg::ST_REV);
  end

  always_comb begin
    state_nxt = state_r;
    if (step.adv) begin
      state_nxt = term ? vsr_pkg::ST_START : trans;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vsr_pkg::ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign scan_state = state_r;

endmodule
`default_nettype wire

// ===== rtl/vsr_out_reg.sv =====
// Result register of the recogniser: holds one verdict until it is taken.
// No package dependencies.
`default_nettype none
module vsr_out_reg (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire logic verdict,
  input  wire logic out_ready,
  output logic      out_valid,
  output logic      out_is_version,
  output logic      free
);

  logic vld_r;
  logic vld_nxt;
  logic data_r;
  logic data_nxt;

  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (load) begin
      vld_nxt  = 1'b1;
      data_nxt = verdict;
    end else if (out_ready) begin
      vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid      = vld_r;
  assign out_is_version = data_r;

endmodule
`default_nettype wire

// ===== rtl/version_string_recognizer.sv =====
// Top level of the version string recogniser: input register, scanner and
// result register. Depends on vsr_pkg, vsr_dfa and vsr_out_reg.
//
//   port group   dir  handshake             payload
//   in_*         in   in_valid / in_ready   in_char_in[7:0]
//   out_*        out  out_valid / out_ready out_is_version
//
// One byte per clock is taken unless a zero byte is held; the scan state steps once per byte in vsr_dfa.
// A verdict is loaded into the result register as its zero byte leaves the input register.
// Only a zero byte waits on the result register; bytes behind a held zero
// byte stall at the input until the pending verdict is taken.
// Synchronous reset returns the scanner to its start state and empties both
// the input and the result register.
`default_nettype none
module version_string_recognizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_is_version
);

  logic                 in_vld_r;
  logic                 in_vld_nxt;
  vsr_pkg::char_t       in_char_r;
  vsr_pkg::char_t       in_char_nxt;
  logic                 term;
  logic                 adv;
  logic                 out_free;
  logic                 verdict;
  vsr_pkg::step_t       step;
  vsr_pkg::scan_state_t scan_state;

  assign term     = (in_char_r == vsr_pkg::CH_NUL);
  // hold a zero byte while an untaken verdict sits in the result register
  assign adv      = in_vld_r && (!term || out_free);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_char_nxt = in_char_r;
    if (in_valid && in_ready) begin
      in_vld_nxt  = 1'b1;
      in_char_nxt = in_char_in;
    end else if (adv) begin
      in_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_char_r <= in_char_nxt;
  end

  assign step.adv = adv;
  assign step.chr = in_char_r;

  vsr_dfa u_dfa (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .verdict    (verdict),
    .scan_state (scan_state)
  );

  vsr_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (adv && term),
    .verdict        (verdict),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_is_version (out_is_version),
    .free           (out_free)
  );

`ifndef SYNTH
  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && term) |=> (scan_state == vsr_pkg::ST_START))
    else $error("scanner did not restart after a terminator");

  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && term) |=> out_valid)
    else $error("terminator transfer produced no verdict");

  a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_state == vsr_pkg::ST_REJ && adv && !term)
      |=> (scan_state == vsr_pkg::ST_REJ))
    else $error("reject state left before terminator");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input register empty but not ready");

  a_hold_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_is_version)))
    else $error("pending verdict overwritten");
`endif

endmodule
`default_nettype wire

// ===== test/version_string_recognizer_test.sv =====
// Self-checking bench for version_string_recognizer: drives byte strings,
// predicts each verdict with its own scan DFA and compares on the result side.
// Depends on vsr_pkg and the recogniser RTL only.
`default_nettype none
module version_string_recognizer_test;

  typedef vsr_pkg::char_t word_t[$];

  typedef struct packed {
    logic           drain_first;
    vsr_pkg::char_t chr;
  } char_item_t;

  localparam int unsigned RANDOM_CHARS = 600;

  logic           clk            = 1'b0;
  logic           rst_n          = 1'b0;
  logic           in_valid       = 1'b0;
  logic           in_ready;
  vsr_pkg::char_t in_char_in     = vsr_pkg::CH_NUL;
  logic           out_valid;
  logic           out_ready      = 1'b0;
  logic           out_is_version;

  char_item_t           pending_chars[$];
  logic                 expected_verdicts[$];
  word_t                word_buf;
  vsr_pkg::scan_state_t model_state = vsr_pkg::ST_START;
  logic                 char_taken  = 1'b0;

  int unsigned total_chars;
  int unsigned chars_taken;
  int unsigned strings_sent;
  int unsigned results_seen;
  int unsigned versions_seen;
  int unsigned errors;
  int unsigned rx_hold_left;
  int unsigned rx_holds_done;

  version_string_recognizer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_version (out_is_version)
  );

  always #5 clk = ~clk;

  function automatic logic is_digit(input vsr_pkg::char_t c);
    return c >= vsr_pkg::CH_0 && c <= vsr_pkg::CH_9;
  endfunction

  function automatic logic is_letter(input vsr_pkg::char_t c);
    return (c >= vsr_pkg::CH_UC_A && c <= vsr_pkg::CH_UC_Z) ||
           (c >= vsr_pkg::CH_LC_A && c <= vsr_pkg::CH_LC_Z);
  endfunction

  // Transition out of a finished suffix name or its digits
  function automatic vsr_pkg::scan_state_t past_suffix(input vsr_pkg::char_t c);
    if (is_digit(c)) return vsr_pkg::ST_SFX;
    if (c == vsr_pkg::CH_US) return vsr_pkg::ST_US;
    if (c == vsr_pkg::CH_DASH) return vsr_pkg::ST_DASH;
    return vsr_pkg::ST_REJ;
  endfunction

  function automatic vsr_pkg::scan_state_t dfa_next(input vsr_pkg::scan_state_t s,
                                                    input vsr_pkg::char_t c);
    case (s)
      vsr_pkg::ST_START: return is_digit(c) ? vsr_pkg::ST_NUM : vsr_pkg::ST_REJ;
      vsr_pkg::ST_NUM: begin
        if (is_digit(c)) return vsr_pkg::ST_NUM;
        if (c == vsr_pkg::CH_DOT) return vsr_pkg::ST_DOT;
        if (is_letter(c)) return vsr_pkg::ST_LET;
        if (c == vsr_pkg::CH_US) return vsr_pkg::ST_US;
        if (c == vsr_pkg::CH_DASH) return vsr_pkg::ST_DASH;
        return vsr_pkg::ST_REJ;
      end
      vsr_pkg::ST_DOT: return is_digit(c) ? vsr_pkg::ST_NUM : vsr_pkg::ST_REJ;
      vsr_pkg::ST_LET: begin
        if (c == vsr_pkg::CH_US) return vsr_pkg::ST_US;
        if (c == vsr_pkg::CH_DASH) return vsr_pkg::ST_DASH;
        return vsr_pkg::ST_REJ;
      end
      vsr_pkg::ST_US: begin
        if (c == vsr_pkg::CH_LC_A) return vsr_pkg::ST_A1;
        if (c == vsr_pkg::CH_B) return vsr_pkg::ST_B1;
        if (c == vsr_pkg::CH_P) return vsr_pkg::ST_P1;
        if (c == vsr_pkg::CH_R) return vsr_pkg::ST_R1;
        return vsr_pkg::ST_REJ;
      end
      vsr_pkg::ST_A1:
        return (c == vsr_pkg::CH_L) ? vsr_pkg::ST_A2 : vsr_pkg::ST_REJ;
      vsr_pkg::ST_A2:
        return (c == vsr_pkg::CH_P) ? vsr_pkg::ST_A3 : vsr_pkg::ST_REJ;
      vsr_pkg::ST_A3:
        return (c == vsr_pkg::CH_H) ? vsr_pkg::ST_A4 : vsr_pkg::ST_REJ;
      vsr_pkg::ST_A4:
        return (c == vsr_pkg::CH_LC_A) ? vsr_pkg::ST_SFX : vsr_pkg::ST_REJ;
      vsr_pkg::ST_B1:
        return (c == vsr_pkg::CH_E) ? vsr_pkg::ST_B2 : vsr_pkg::ST_REJ;
      vsr_pkg::ST_B2:
        return (c == vsr_pkg::CH_T) ? vsr_pkg::ST_B3 : vsr_pkg::ST_REJ;
      vsr_pkg::ST_B3:
        return (c == vsr_pkg::CH_LC_A) ? vsr_pkg::ST_SFX : vsr_pkg::ST_REJ;
      vsr_pkg::ST_R1:
        return (c == vsr_pkg::CH_C) ? vsr_pkg::ST_SFX : vsr_pkg::ST_REJ;
      vsr_pkg::ST_P1:
        return (c == vsr_pkg::CH_R) ? vsr_pkg::ST_PR : past_suffix(c);
      vsr_pkg::ST_PR:
        return (c == vsr_pkg::CH_E) ? vsr_pkg::ST_SFX : vsr_pkg::ST_REJ;
      vsr_pkg::ST_SFX:  return past_suffix(c);
      vsr_pkg::ST_DASH:
        return (c == vsr_pkg::CH_R) ? vsr_pkg::ST_DR : vsr_pkg::ST_REJ;
      vsr_pkg::ST_DR:   return is_digit(c) ? vsr_pkg::ST_REV : vsr_pkg::ST_REJ;
      vsr_pkg::ST_REV:  return is_digit(c) ? vsr_pkg::ST_REV : vsr_pkg::ST_REJ;
      default: return vsr_pkg::ST_REJ;
    endcase
  endfunction

  function automatic logic is_final_state(input vsr_pkg::scan_state_t s);
    return s == vsr_pkg::ST_NUM || s == vsr_pkg::ST_LET || s == vsr_pkg::ST_P1 ||
           s == vsr_pkg::ST_SFX || s == vsr_pkg::ST_REV;
  endfunction

  // Sender idles first lightly, then heavily; receiver the other way round; neither idles in the last third
  function automatic int unsigned stall_pct(input bit receiver);
    if (chars_taken < total_chars / 3) return receiver ? 64 : 6;
    if (chars_taken < 2 * total_chars / 3) return receiver ? 6 : 64;
    return 0;
  endfunction

  // Half the time a byte at the borders of the character classes, otherwise any nonzero byte
  function automatic vsr_pkg::char_t odd_byte();
    vsr_pkg::char_t border [10];
    border = '{8'h01, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(1) == 0) return border[$urandom_range(9)];
    return vsr_pkg::char_t'($urandom_range(1, 255));
  endfunction

  task automatic add_digits(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) word_buf.push_back(vsr_pkg::char_t'(vsr_pkg::CH_0 + $urandom_range(9)));
  endtask

  // Queue the word buffer and its terminator; the flag makes the sender drain first
  task automatic queue_word(input bit drain);
    char_item_t item;
    foreach (word_buf[i]) begin
      item.drain_first = drain && (i == 0);
      item.chr         = word_buf[i];
      pending_chars.push_back(item);
    end
    item.drain_first = drain && (word_buf.size() == 0);
    item.chr         = vsr_pkg::CH_NUL;
    pending_chars.push_back(item);
    strings_sent++;
  endtask

  task automatic queue_text(input string txt);
    word_buf.delete();
    for (int i = 0; i < txt.len(); i++) word_buf.push_back(vsr_pkg::char_t'(txt[i]));
    queue_word(1'b0);
  endtask

  // Driver: offer the next byte once the current one has transferred
  always @(negedge clk) begin : char_source
    logic offer;
    offer = in_valid && !char_taken;
    if (!offer && rst_n && pending_chars.size() != 0 &&
        $urandom_range(99) >= stall_pct(1'b0) &&
        !(pending_chars[0].drain_first && expected_verdicts.size() != 0)) begin
      in_char_in <= pending_chars[0].chr;
      pending_chars.pop_front();
      offer = 1'b1;
    end
    in_valid <= offer;
  end

  // Receiver: random stalls plus a few long hold-offs to back the block up
  always @(negedge clk) begin : result_sink
    logic rdy;
    rdy = $urandom_range(99) >= stall_pct(1'b1);
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      rdy = 1'b0;
    end else if (rx_holds_done < 3 && results_seen >= 10 + 25 * rx_holds_done) begin
      rx_hold_left  <= 80;
      rx_holds_done <= rx_holds_done + 1;
      rdy = 1'b0;
    end
    out_ready <= rdy;
  end

  // Monitor: check verdicts, then advance the predicted scan state
  always @(posedge clk) begin : scan_monitor
    logic want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_is_version === 1'b1) versions_seen++;
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict, actual %b", $time, out_is_version);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_is_version !== want) begin
            errors++;
            $display("%0t: is_version mismatch, expected %b actual %b",
                     $time, want, out_is_version);
          end
        end
      end
      if (in_valid && in_ready) begin
        chars_taken++;
        if (in_char_in == vsr_pkg::CH_NUL) begin
          expected_verdicts.push_back(is_final_state(model_state));
          model_state = vsr_pkg::ST_START;
        end else begin
          model_state = dfa_next(model_state, in_char_in);
        end
      end
    end
    char_taken <= rst_n && in_valid && in_ready;
  end

  initial begin : stimulus
    int unsigned    directed_chars;
    int unsigned    kind;
    int unsigned    n;
    int unsigned    pos;
    vsr_pkg::char_t b;

    // Directed: empty string, p against pre, dangling separators, letters,
    // a high byte followed by a digit in the sticky reject
    queue_text("");
    queue_text("0_p");
    queue_text("1_pr");
    queue_text("5Z-r9");
    queue_text("1.");
    queue_text("7_alpha_beta2_rc_pre10-r");
    word_buf.delete();
    word_buf.push_back(vsr_pkg::char_t'("1"));
    word_buf.push_back(8'hFF);
    word_buf.push_back(vsr_pkg::char_t'("9"));
    queue_word(1'b0);
    directed_chars = pending_chars.size();

    n = 0;
    while (pending_chars.size() < directed_chars + RANDOM_CHARS) begin
      word_buf.delete();
      kind = $urandom_range(99);
      if (kind < 12) begin
        repeat ($urandom_range(0, 7)) word_buf.push_back(odd_byte());
      end else begin
        add_digits(1, 3);
        repeat ($urandom_range(0, 2)) begin
          word_buf.push_back(vsr_pkg::CH_DOT);
          add_digits(1, 2);
        end
        if ($urandom_range(3) == 0)
          word_buf.push_back($urandom_range(1) ?
                             vsr_pkg::char_t'(vsr_pkg::CH_UC_A + $urandom_range(25)) :
                             vsr_pkg::char_t'(vsr_pkg::CH_LC_A + $urandom_range(25)));
        repeat ($urandom_range(0, 2)) begin
          word_buf.push_back(vsr_pkg::CH_US);
          case ($urandom_range(4))
            0: begin
              word_buf.push_back(vsr_pkg::CH_LC_A);
              word_buf.push_back(vsr_pkg::CH_L);
              word_buf.push_back(vsr_pkg::CH_P);
              word_buf.push_back(vsr_pkg::CH_H);
              word_buf.push_back(vsr_pkg::CH_LC_A);
            end
            1: begin
              word_buf.push_back(vsr_pkg::CH_B);
              word_buf.push_back(vsr_pkg::CH_E);
              word_buf.push_back(vsr_pkg::CH_T);
              word_buf.push_back(vsr_pkg::CH_LC_A);
            end
            2: begin
              word_buf.push_back(vsr_pkg::CH_P);
              word_buf.push_back(vsr_pkg::CH_R);
              word_buf.push_back(vsr_pkg::CH_E);
            end
            3: begin
              word_buf.push_back(vsr_pkg::CH_R);
              word_buf.push_back(vsr_pkg::CH_C);
            end
            default: word_buf.push_back(vsr_pkg::CH_P);
          endcase
          add_digits(0, 2);
        end
        if ($urandom_range(1) == 0) begin
          word_buf.push_back(vsr_pkg::CH_DASH);
          word_buf.push_back(vsr_pkg::CH_R);
          add_digits(1, 2);
        end
        // Break about a quarter of the well-formed strings
        if (kind < 35) begin
          pos = $urandom_range(word_buf.size() - 1);
          case ($urandom_range(2))
            0: while (word_buf.size() > pos) word_buf.pop_back();
            1: word_buf[pos] = odd_byte();
            default: begin
              b = odd_byte();
              word_buf.insert(pos, b);
            end
          endcase
        end
      end
      queue_word(n == 0 || n == 30 || n == 55);
      n++;
    end
    total_chars = pending_chars.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d strings (%0d bytes); %0d verdicts checked, %0d of them versions.",
             strings_sent, total_chars, results_seen, versions_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d verdicts still awaited", expected_verdicts.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/vsr_pkg.sv
rtl/vsr_dfa.sv
rtl/vsr_out_reg.sv
rtl/version_string_recognizer.sv
test/version_string_recognizer_test.sv
